// File: sv/mrf_icm_pkg.sv
`timescale 1ns / 1ps

package mrf_icm_pkg;

    localparam int CLASSES       = 3;
    localparam int NEIGHBORS     = 6;
    localparam int VALUE_BITS    = 32;

    // Field widths fixed by the interface.
    localparam int MAX_CLASSES   = 3;
    localparam int MAX_NEIGHBORS = 6;
    localparam int ADDR_W        = 16;
    localparam int LABEL_W       = 2;
    localparam int FIELD_W       = 32;
    localparam int SCORE_W       = 64;

    localparam int RADIX         = NEIGHBORS + 1;
    localparam int SPAN          = RADIX ** CLASSES;
    localparam int TABLE_DEPTH   = CLASSES * SPAN;
    localparam int CODE_W        = $clog2(SPAN);
    localparam int CNT_W         = $clog2(NEIGHBORS + 1);
    localparam int BANK_W        = $clog2(CLASSES);
    localparam int PROD_W        = 2 * VALUE_BITS;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [PROD_W-1:0]     prod_t;
    typedef logic [CODE_W-1:0]     code_t;
    typedef logic [CNT_W-1:0]      count_t;
    typedef logic [BANK_W-1:0]     bank_t;
    typedef logic [LABEL_W-1:0]    label_t;
    typedef logic [ADDR_W-1:0]     addr_t;

    localparam logic REQ_CLASSIFY = 1'b0;
    localparam logic REQ_WRITE    = 1'b1;

    // Weight of class j in the mixed-radix neighbor code.
    function automatic int radix_pow(input int j);
        int p;
        p = 1;
        for (int k = 0; k < j; k++)
        begin
            p = p * RADIX;
        end
        return p;
    endfunction

endpackage

// File: sv/mrf_icm_label_update.sv
`timescale 1ns / 1ps
// A classify item passes through the s1, s2, s3, s4 and out registers to the output.
// Throughput: one item per cycle; the input takes a new item whenever the pipeline moves.
// Write items update the prior-weight banks at the first edge after acceptance at which
// the pipeline moves, and give no result.
// Reset (rst_n low, asynchronous) clears all valid flags; the weight banks hold no reset
// value and must be written before they are read.
module mrf_icm_label_update
    import mrf_icm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // address[15:0], neighbor_label_0..5[27:16], density_0[59:28], density_1[91:60],
    // density_2[123:92], table_value[155:124], zero pad[159:156]
    input  logic [159:0] s_axis_tdata,
    // req_type[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // voxel_tag[15:0], new_label[17:16], best_score[81:18], zero pad[87:82]
    output logic [87:0]  m_axis_tdata
);

    localparam int LABEL_LSB = ADDR_W;
    localparam int DENS_LSB  = LABEL_LSB + MAX_NEIGHBORS * LABEL_W;
    localparam int VALUE_LSB = DENS_LSB + MAX_CLASSES * FIELD_W;

    // ---------------- stage 1: neighbor code and write decode ----------------
    logic   s1_valid_reg;
    logic   s1_is_write_reg;
    logic   s1_wr_ok_reg;
    bank_t  s1_bank_reg;
    code_t  s1_offset_reg;
    value_t s1_value_reg;
    addr_t  s1_tag_reg;
    code_t  s1_code_reg;
    value_t s1_dens_reg [CLASSES];

    logic   s2_valid_reg;
    addr_t  s2_tag_reg;
    value_t s2_dens_reg [CLASSES];
    value_t s2_weight   [CLASSES];

    logic   s3_valid_reg;
    addr_t  s3_tag_reg;
    prod_t  s3_prod_reg [CLASSES];

    logic   s4_valid_reg;
    addr_t  s4_tag_reg;
    prod_t  s4_prod_reg [CLASSES];
    prod_t  s4_best_reg;
    label_t s4_label_reg;

    logic   out_valid_reg;
    addr_t  out_tag_reg;
    label_t out_label_reg;
    prod_t  out_score_reg;

    logic   s1_en;
    logic   s2_en;
    logic   s3_en;
    logic   s4_en;
    logic   out_en;

    label_t labels [MAX_NEIGHBORS];
    count_t counts [CLASSES];
    code_t  code_next;
    addr_t  in_addr;
    logic   wr_ok_next;
    bank_t  bank_next;
    code_t  offset_next;

    prod_t  s4_best_next;
    label_t s4_label_next;
    prod_t  out_score_next;
    label_t out_label_next;

    assign out_en        = !out_valid_reg || m_axis_tready;
    assign s4_en         = !s4_valid_reg || out_en;
    assign s3_en         = !s3_valid_reg || s4_en;
    assign s2_en         = !s2_valid_reg || s3_en;
    assign s1_en         = !s1_valid_reg || s2_en;
    assign s_axis_tready = s1_en;

    assign in_addr = s_axis_tdata[ADDR_W-1:0];

    always_comb
    begin
        for (int m = 0; m < MAX_NEIGHBORS; m++)
        begin
            labels[m] = s_axis_tdata[LABEL_LSB + m * LABEL_W +: LABEL_W];
        end
        for (int j = 0; j < CLASSES; j++)
        begin
            counts[j] = '0;
        end
        // A label of CLASSES or more (outside the image) matches no class.
        for (int m = 0; m < NEIGHBORS; m++)
        begin
            for (int j = 0; j < CLASSES; j++)
            begin
                if (labels[m] == LABEL_W'(j))
                begin
                    counts[j] = counts[j] + 1'b1;
                end
            end
        end
        code_next = '0;
        for (int j = 0; j < CLASSES; j++)
        begin
            code_next = code_next + CODE_W'(counts[j]) * CODE_W'(radix_pow(j));
        end
    end

    // The flat table index splits into a bank (class) and an offset (code).
    always_comb
    begin
        wr_ok_next  = in_addr < ADDR_W'(TABLE_DEPTH);
        bank_next   = '0;
        offset_next = in_addr[CODE_W-1:0];
        for (int j = 1; j < CLASSES; j++)
        begin
            if (in_addr >= ADDR_W'(j * SPAN))
            begin
                bank_next   = BANK_W'(j);
                offset_next = CODE_W'(in_addr - ADDR_W'(j * SPAN));
            end
        end
    end

    // ---------------- stage 4 and 5 compare ----------------
    always_comb
    begin
        if (s3_prod_reg[1] > s3_prod_reg[0])
        begin
            s4_best_next  = s3_prod_reg[1];
            s4_label_next = LABEL_W'(1);
        end
        else
        begin
            s4_best_next  = s3_prod_reg[0];
            s4_label_next = '0;
        end
    end

    always_comb
    begin
        out_score_next = s4_best_reg;
        out_label_next = s4_label_reg;
        for (int j = 2; j < CLASSES; j++)
        begin
            if (s4_prod_reg[j] > out_score_next)
            begin
                out_score_next = s4_prod_reg[j];
                out_label_next = LABEL_W'(j);
            end
        end
    end

    // ---------------- valid flags ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            // Write items leave the pipeline once the bank has been updated.
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg && (s1_is_write_reg == REQ_CLASSIFY);
            end
            if (s3_en)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_en)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (out_en)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (s1_en && s_axis_tvalid)
        begin
            s1_is_write_reg <= s_axis_tuser[0];
            s1_wr_ok_reg    <= wr_ok_next;
            s1_bank_reg     <= bank_next;
            s1_offset_reg   <= offset_next;
            s1_value_reg    <= s_axis_tdata[VALUE_LSB +: VALUE_BITS];
            s1_tag_reg      <= in_addr;
            s1_code_reg     <= code_next;
            for (int j = 0; j < CLASSES; j++)
            begin
                s1_dens_reg[j] <= s_axis_tdata[DENS_LSB + j * FIELD_W +: VALUE_BITS];
            end
        end
        if (s2_en)
        begin
            s2_tag_reg <= s1_tag_reg;
            for (int j = 0; j < CLASSES; j++)
            begin
                s2_dens_reg[j] <= s1_dens_reg[j];
            end
        end
        if (s3_en)
        begin
            s3_tag_reg <= s2_tag_reg;
            for (int j = 0; j < CLASSES; j++)
            begin
                s3_prod_reg[j] <= PROD_W'(s2_dens_reg[j]) * PROD_W'(s2_weight[j]);
            end
        end
        if (s4_en)
        begin
            s4_tag_reg   <= s3_tag_reg;
            s4_best_reg  <= s4_best_next;
            s4_label_reg <= s4_label_next;
            for (int j = 0; j < CLASSES; j++)
            begin
                s4_prod_reg[j] <= s3_prod_reg[j];
            end
        end
        if (out_en)
        begin
            out_tag_reg   <= s4_tag_reg;
            out_label_reg <= out_label_next;
            out_score_reg <= out_score_next;
        end
    end

    // ---------------- weight banks, one per class ----------------
    for (genvar j = 0; j < CLASSES; j++)
    begin : g_bank
        value_t bank_mem [SPAN];
        value_t rd_data_reg;

        always_ff @(posedge clk)
        begin
            if (s2_en && s1_valid_reg && (s1_is_write_reg == REQ_WRITE) && s1_wr_ok_reg
                && (s1_bank_reg == BANK_W'(j)))
            begin
                bank_mem[s1_offset_reg] <= s1_value_reg;
            end
            if (s2_en && s1_valid_reg && (s1_is_write_reg == REQ_CLASSIFY))
            begin
                rd_data_reg <= bank_mem[s1_code_reg];
            end
        end

        assign s2_weight[j] = rd_data_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, SCORE_W'(out_score_reg), out_label_reg, out_tag_reg};

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb
    import mrf_icm_pkg::*;
();

    localparam int     CYCLE_LIMIT = 200000;
    localparam int     HOLD_CYCLES = 80;
    localparam int     DRAIN_WAIT  = 12;
    localparam label_t OUTSIDE     = 2'd3;

    typedef struct packed {
        logic                                   req;
        addr_t                                  address;
        logic [MAX_NEIGHBORS-1:0][LABEL_W-1:0]  nbr;
        logic [MAX_CLASSES-1:0][FIELD_W-1:0]    dens;
        logic [FIELD_W-1:0]                     weight;
    } voxel_req_t;

    typedef struct packed {
        addr_t  tag;
        label_t label;
        prod_t  score;
    } voxel_result_t;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata  = '0;
    logic [0:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [87:0]  m_axis_tdata;

    value_t          prior_weights  [TABLE_DEPTH];
    bit              weight_written [TABLE_DEPTH];
    voxel_result_t   pending_labels [$];
    voxel_result_t   oldest_label;
    int              mismatch_count = 0;
    int              items_sent     = 0;
    int              cycle_count    = 0;
    int              hold_requests  = 0;
    int              hold_served    = 0;
    int              hold_left      = 0;
    int              stall_left     = 0;
    bit              drain_quiet    = 1'b0;

    mrf_icm_label_update DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Mixed-radix index of the neighbor class counts; labels past the last class count nowhere.
    function automatic int neighbor_code(logic [MAX_NEIGHBORS-1:0][LABEL_W-1:0] nbr);
        int tally [MAX_CLASSES];
        int code;
        int scale;
        for (int j = 0; j < MAX_CLASSES; j++)
        begin
            tally[j] = 0;
        end
        for (int m = 0; m < NEIGHBORS; m++)
        begin
            if (nbr[m] < CLASSES)
            begin
                tally[nbr[m]]++;
            end
        end
        code  = 0;
        scale = 1;
        for (int j = 0; j < CLASSES; j++)
        begin
            code  += tally[j] * scale;
            scale *= RADIX;
        end
        return code;
    endfunction

    function automatic voxel_result_t icm_choose_label(voxel_req_t v);
        voxel_result_t r;
        prod_t         prod;
        int            code;
        code    = neighbor_code(v.nbr);
        r.tag   = v.address;
        r.label = '0;
        r.score = '0;
        for (int j = 0; j < CLASSES; j++)
        begin
            prod = prod_t'(value_t'(v.dens[j])) * prod_t'(prior_weights[j * SPAN + code]);
            if (j == 0 || prod > r.score)
            begin
                r.score = prod;
                r.label = label_t'(j);
            end
        end
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    // Fields a request does not use still carry random data.
    function automatic voxel_req_t make_write(int address, logic [FIELD_W-1:0] value);
        voxel_req_t v;
        v.req     = REQ_WRITE;
        v.address = addr_t'(address);
        for (int m = 0; m < MAX_NEIGHBORS; m++)
        begin
            v.nbr[m] = label_t'($urandom_range(0, 3));
        end
        for (int j = 0; j < MAX_CLASSES; j++)
        begin
            v.dens[j] = $urandom;
        end
        v.weight = value;
        return v;
    endfunction

    function automatic voxel_req_t make_classify(
        int tag,
        logic [MAX_NEIGHBORS-1:0][LABEL_W-1:0] nbr,
        logic [FIELD_W-1:0] d0,
        logic [FIELD_W-1:0] d1,
        logic [FIELD_W-1:0] d2
    );
        voxel_req_t v;
        v.req     = REQ_CLASSIFY;
        v.address = addr_t'(tag);
        v.nbr     = nbr;
        v.dens[0] = d0;
        v.dens[1] = d1;
        v.dens[2] = d2;
        v.weight  = $urandom;
        return v;
    endfunction

    // Valid is left high after acceptance, so back-to-back items keep it asserted between them.
    task automatic send_item(voxel_req_t v);
        int gap;
        if (!drain_quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 5);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= v.req;
        s_axis_tdata  <= {4'b0, v.weight, v.dens, v.nbr, v.address};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        items_sent++;
        if (v.req == REQ_WRITE)
        begin
            if (v.address < TABLE_DEPTH)
            begin
                prior_weights[v.address]  = value_t'(v.weight);
                weight_written[v.address] = 1'b1;
            end
        end
        else
        begin
            pending_labels.push_back(icm_choose_label(v));
        end
    endtask

    task automatic send_voxel(logic [MAX_NEIGHBORS-1:0][LABEL_W-1:0] nbr);
        int                 code;
        int                 idx;
        logic [FIELD_W-1:0] d0;
        code = neighbor_code(nbr);
        for (int j = 0; j < CLASSES; j++)
        begin
            idx = j * SPAN + code;
            if (!weight_written[idx])
            begin
                send_item(make_write(idx, rand_value()));
            end
        end
        d0 = rand_value();
        // Equal densities now and then so that ties hinge on the weights alone.
        if ($urandom_range(0, 7) == 0)
        begin
            send_item(make_classify($urandom_range(0, 65535), nbr, d0, d0, d0));
        end
        else
        begin
            send_item(make_classify($urandom_range(0, 65535), nbr, d0, rand_value(),
                                    rand_value()));
        end
    endtask

    task automatic send_random_voxel();
        logic [MAX_NEIGHBORS-1:0][LABEL_W-1:0] nbr;
        label_t                                base;
        base = label_t'($urandom_range(0, 3));
        for (int m = 0; m < MAX_NEIGHBORS; m++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                nbr[m] = base;
            end
            else
            begin
                nbr[m] = label_t'($urandom_range(0, 3));
            end
        end
        send_voxel(nbr);
    endtask

    task automatic test_extreme_values();
        logic [MAX_NEIGHBORS-1:0][LABEL_W-1:0] nbr;
        nbr = {MAX_NEIGHBORS{OUTSIDE}};
        send_item(make_write(0, '1));
        send_item(make_write(SPAN, '1));
        send_item(make_write(2 * SPAN, '1));
        send_item(make_classify(16'hFFFF, nbr, '1, '1, '1));
        send_item(make_classify(0, nbr, '0, '0, '1));
        send_item(make_classify(16'h5A5A, nbr, 32'd1, '0, '0));
    endtask

    task automatic test_zero_products();
        logic [MAX_NEIGHBORS-1:0][LABEL_W-1:0] nbr;
        int                                    code;
        nbr  = '0;
        code = neighbor_code(nbr);
        for (int j = 0; j < CLASSES; j++)
        begin
            send_item(make_write(j * SPAN + code, '0));
        end
        send_item(make_classify(16'h8001, nbr, '1, '1, '1));
    endtask

    task automatic test_ties();
        logic [MAX_NEIGHBORS-1:0][LABEL_W-1:0] nbr;
        int                                    code;
        nbr  = {MAX_NEIGHBORS{2'd2}};
        code = neighbor_code(nbr);
        send_item(make_write(code, 32'd2));
        send_item(make_write(SPAN + code, 32'd1));
        send_item(make_write(2 * SPAN + code, 32'd1));
        send_item(make_classify(16'h0101, nbr, 32'd1, 32'd2, 32'd2));
        send_item(make_classify(16'h0202, nbr, 32'd1, 32'd4, 32'd4));
    endtask

    task automatic test_write_range();
        logic [MAX_NEIGHBORS-1:0][LABEL_W-1:0] nbr;
        // Writes past the last entry must leave the table alone.
        send_item(make_write(TABLE_DEPTH, 32'd7));
        send_item(make_write(16'hFFFF, 32'd9));
        send_item(make_write(TABLE_DEPTH - 1, 32'hDEAD_BEEF));
        nbr = {MAX_NEIGHBORS{OUTSIDE}};
        send_item(make_classify(16'h1234, nbr, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000));
        nbr = {2'd2, 2'd1, OUTSIDE, 2'd2, 2'd1, 2'd0};
        send_voxel(nbr);
    endtask

    task automatic test_random_voxels();
        int pick;
        while (items_sent < 470)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 15)
            begin
                send_random_voxel();
            end
            else if (pick < 18)
            begin
                send_item(make_write($urandom_range(0, TABLE_DEPTH - 1), rand_value()));
            end
            else
            begin
                send_item(make_write($urandom_range(TABLE_DEPTH, 65535), rand_value()));
            end
        end
    endtask

    // The output side holds off for a long stretch while items keep coming.
    task automatic test_output_hold();
        hold_requests++;
        repeat (12) send_random_voxel();
    endtask

    task automatic test_unthrottled();
        drain_quiet = 1'b1;
        while (items_sent < 600)
        begin
            send_random_voxel();
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else if (drain_quiet)
            begin
                m_axis_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_labels.size() == 0)
            begin
                $error("unexpected result: tag %0d", m_axis_tdata[15:0]);
                mismatch_count++;
            end
            else
            begin
                oldest_label = pending_labels.pop_front();
                if (m_axis_tdata[15:0] !== oldest_label.tag)
                begin
                    $error("voxel_tag: expected %0d, got %0d", oldest_label.tag,
                           m_axis_tdata[15:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[17:16] !== oldest_label.label)
                begin
                    $error("new_label: expected %0d, got %0d", oldest_label.label,
                           m_axis_tdata[17:16]);
                    mismatch_count++;
                end
                if (m_axis_tdata[81:18] !== oldest_label.score)
                begin
                    $error("best_score: expected %h, got %h", oldest_label.score,
                           m_axis_tdata[81:18]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extreme_values();
        test_zero_products();
        test_ties();
        test_write_range();
        test_random_voxels();
        test_output_hold();
        test_unthrottled();
        s_axis_tvalid <= 1'b0;
        while (pending_labels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
